// ===== design/rsc_pkg.sv =====
// Shared codes, widths and constants of the RPN stack calculator.
package rsc_pkg;

  // Item field widths
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // Function codes of an input item
  localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 3'd5;

  // Status codes of a result item
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

  // Value taken for a pop from an empty stack
  localparam logic [VALUE_W-1:0] EMPTY_POP_VALUE = 32'h8000_0001;

endpackage

// ===== design/rsc_in_if.sv =====
// Command channel of the RPN stack calculator: function code and operand.
interface rsc_in_if import rsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [FUNC_W-1:0]  func;
  logic signed [VALUE_W-1:0] operand_value;

  modport source (output valid, output func, output operand_value, input ready);
  modport sink   (input valid, input func, input operand_value, output ready);
endinterface

// ===== design/rsc_out_if.sv =====
// Result channel of the RPN stack calculator: value, status and stack fill.
interface rsc_out_if import rsc_pkg::*; #(
  parameter int unsigned CNT_W = 5
) ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  result_value;
  logic        [STATUS_W-1:0] status;
  logic        [CNT_W-1:0]    entry_count;

  modport source (output valid, output result_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input result_value, input status, input entry_count,
                  output ready);
endinterface

// ===== design/rpn_stack_calculator.sv =====
// RPN stack calculator: operand stack in a memory and one shared 33-bit adder under a sequencer.
//
// Every command item yields exactly one result item. The block takes one item at a time;
// cmd_i.ready is high only while the sequencer is idle. Multiply runs 32 shift-and-add steps
// on the shared adder; divide runs operand sign removal, 32 restoring steps and a sign fix on
// the same adder, and a divide by zero skips those steps. The operand stack is a single-port-read
// memory with registered read data. A finished result sits in an output register, so the next
// item is taken while it waits; a further result then waits until the output register drains.
// entry_count is $clog2(STACK_DEPTH+1) bits wide. The stack needs no clearing after reset.
module rpn_stack_calculator import rsc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsc_in_if.sink    cmd_i,
  rsc_out_if.source res_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] CNT_DEPTH = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] CNT_ONE   = CW'(1);
  localparam logic [CW-1:0] CNT_TWO   = CW'(2);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TOP  = 4'd1;
  localparam logic [3:0] S_GETA = 4'd2;
  localparam logic [3:0] S_GETB = 4'd3;
  localparam logic [3:0] S_EXEC = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_ABSB = 4'd6;
  localparam logic [3:0] S_ABSA = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_FIX  = 4'd9;
  localparam logic [3:0] S_PUSH = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]          state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [FUNC_W-1:0]   func_q, func_d;
  logic                under_q, under_d;
  logic                dz_q, dz_d;
  logic                na_q, na_d;
  logic                nb_q, nb_d;
  logic [4:0]          step_q, step_d;
  logic [VALUE_W-1:0]  a_q, a_d;
  logic [VALUE_W-1:0]  b_q, b_d;
  logic [VALUE_W-1:0]  rem_q, rem_d;
  logic [VALUE_W-1:0]  res_q, res_d;
  logic [STATUS_W-1:0] stat_q, stat_d;
  logic                out_val_q, out_val_d;
  logic                out_load;
  logic [VALUE_W-1:0]  out_res_q;
  logic [STATUS_W-1:0] out_stat_q;
  logic [CW-1:0]       out_cnt_q;

  logic [CW-1:0]       cnt_m1, cnt_m2;
  logic                cmd_fire;

  // Stack memory
  logic [VALUE_W-1:0]  mem_q [STACK_DEPTH];
  logic [VALUE_W-1:0]  rd_q;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [VALUE_W-1:0]  wr_data;

  // Shared adder
  logic [VALUE_W:0]    add_x, add_y, add_sum;
  logic                add_sub;
  logic [VALUE_W-1:0]  div_shift;

  assign cnt_m1    = cnt_q - CNT_ONE;
  assign cnt_m2    = cnt_q - CNT_TWO;
  assign cmd_fire  = cmd_i.valid && cmd_i.ready;
  assign div_shift = {rem_q[VALUE_W-2:0], b_q[VALUE_W-1]};

  // Write and read the stack, read data registered
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Select adder operands by sequencer step
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state_q)
      S_EXEC: begin
        add_x   = {1'b0, b_q};
        add_y   = {1'b0, a_q};
        add_sub = (func_q == FUNC_SUB);
      end
      S_MUL: begin
        add_x = {1'b0, rem_q};
        add_y = b_q[0] ? {1'b0, a_q} : '0;
      end
      S_ABSB, S_FIX: begin
        add_y   = {1'b0, b_q};
        add_sub = 1'b1;
      end
      S_ABSA: begin
        add_y   = {1'b0, a_q};
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_x   = {rem_q, b_q[VALUE_W-1]};
        add_y   = {1'b0, a_q};
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_sum = add_x + (add_sub ? ~add_y : add_y) + {{VALUE_W{1'b0}}, add_sub};

  // Sequence one item
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    func_d    = func_q;
    under_d   = under_q;
    dz_d      = dz_q;
    na_d      = na_q;
    nb_d      = nb_q;
    step_d    = step_q;
    a_d       = a_q;
    b_d       = b_q;
    rem_d     = rem_q;
    res_d     = res_q;
    stat_d    = stat_q;
    out_load  = 1'b0;
    rd_addr   = cnt_m1[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = cnt_q[AW-1:0];
    wr_data   = res_q;
    out_val_d = out_val_q && !res_o.ready;

    case (state_q)
      S_IDLE: begin
        if (cmd_fire) begin
          func_d  = cmd_i.func;
          under_d = 1'b0;
          dz_d    = 1'b0;
          stat_d  = STATUS_OK;
          case (cmd_i.func)
            FUNC_PUSH: begin
              if (cnt_q < CNT_DEPTH) begin
                wr_en   = 1'b1;
                wr_data = cmd_i.operand_value;
                cnt_d   = cnt_q + CNT_ONE;
                res_d   = cmd_i.operand_value;
                state_d = S_DONE;
              end else begin
                stat_d  = STATUS_FULL;
                state_d = S_TOP;
              end
            end
            FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
              state_d = S_GETA;
            end
            FUNC_POP: begin
              if (cnt_q == '0) begin
                res_d   = EMPTY_POP_VALUE;
                stat_d  = STATUS_UNDERFLOW;
                state_d = S_DONE;
              end else begin
                cnt_d   = cnt_m1;
                state_d = S_TOP;
              end
            end
            default: begin
              if (cnt_q == '0) begin
                res_d   = '0;
                state_d = S_DONE;
              end else begin
                state_d = S_TOP;
              end
            end
          endcase
        end
      end
      S_TOP: begin
        res_d   = rd_q;
        state_d = S_DONE;
      end
      S_GETA: begin
        rd_addr = cnt_m2[AW-1:0];
        if (cnt_q == '0) begin
          a_d     = EMPTY_POP_VALUE;
          under_d = 1'b1;
        end else begin
          a_d   = rd_q;
          cnt_d = cnt_m1;
        end
        state_d = S_GETB;
      end
      S_GETB: begin
        if (cnt_q == '0) begin
          b_d     = EMPTY_POP_VALUE;
          under_d = 1'b1;
        end else begin
          b_d   = rd_q;
          cnt_d = cnt_m1;
        end
        state_d = S_EXEC;
      end
      S_EXEC: begin
        case (func_q)
          FUNC_MUL: begin
            rem_d   = '0;
            step_d  = '0;
            state_d = S_MUL;
          end
          FUNC_DIV: begin
            if (a_q == '0) begin
              res_d   = b_q;
              dz_d    = 1'b1;
              state_d = S_PUSH;
            end else begin
              nb_d    = b_q[VALUE_W-1];
              na_d    = a_q[VALUE_W-1];
              state_d = S_ABSB;
            end
          end
          default: begin
            res_d   = add_sum[VALUE_W-1:0];
            state_d = S_PUSH;
          end
        endcase
      end
      S_MUL: begin
        // Add shifted multiplicand where the multiplier bit is set
        rem_d  = add_sum[VALUE_W-1:0];
        a_d    = {a_q[VALUE_W-2:0], 1'b0};
        b_d    = {1'b0, b_q[VALUE_W-1:1]};
        step_d = step_q + 5'd1;
        if (step_q == 5'd31) begin
          res_d   = add_sum[VALUE_W-1:0];
          state_d = S_PUSH;
        end
      end
      S_ABSB: begin
        if (nb_q) begin
          b_d = add_sum[VALUE_W-1:0];
        end
        state_d = S_ABSA;
      end
      S_ABSA: begin
        if (na_q) begin
          a_d = add_sum[VALUE_W-1:0];
        end
        rem_d   = '0;
        step_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        // Restoring step: keep the difference when it does not go negative
        rem_d  = add_sum[VALUE_W] ? div_shift : add_sum[VALUE_W-1:0];
        b_d    = {b_q[VALUE_W-2:0], ~add_sum[VALUE_W]};
        step_d = step_q + 5'd1;
        if (step_q == 5'd31) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        res_d   = (nb_q ^ na_q) ? add_sum[VALUE_W-1:0] : b_q;
        state_d = S_PUSH;
      end
      S_PUSH: begin
        wr_en   = 1'b1;
        wr_data = res_q;
        cnt_d   = cnt_q + CNT_ONE;
        if (under_q) begin
          stat_d = STATUS_UNDERFLOW;
        end else if (dz_q) begin
          stat_d = STATUS_DIV_ZERO;
        end else begin
          stat_d = STATUS_OK;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_val_q || res_o.ready) begin
          out_load  = 1'b1;
          out_val_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_val_q <= 1'b0;
      step_q    <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_val_q <= out_val_d;
      step_q    <= step_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    under_q <= under_d;
    dz_q    <= dz_d;
    na_q    <= na_d;
    nb_q    <= nb_d;
    a_q     <= a_d;
    b_q     <= b_d;
    rem_q   <= rem_d;
    res_q   <= res_d;
    stat_q  <= stat_d;
    if (out_load) begin
      out_res_q  <= res_q;
      out_stat_q <= stat_q;
      out_cnt_q  <= cnt_q;
    end
  end

  assign cmd_i.ready        = (state_q == S_IDLE);
  assign res_o.valid        = out_val_q;
  assign res_o.result_value = out_res_q;
  assign res_o.status       = out_stat_q;
  assign res_o.entry_count  = out_cnt_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_DEPTH)
    else $error("stack count beyond depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |-> (cnt_q < CNT_DEPTH))
    else $error("operator result pushed onto a full stack");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (a_q != '0))
    else $error("divide step with zero divisor");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_fire |=> (state_q != S_IDLE))
    else $error("sequencer idle right after taking an item");

  a_under_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_val_q && (out_stat_q == STATUS_UNDERFLOW)) |-> (out_cnt_q <= CNT_ONE))
    else $error("underflow reported with more than one entry left");

endmodule
